// ----- hw/rtl/mmls_pkg.sv -----
// Shared types, codes and helper functions for the min/max location search.
// No dependencies; imported by every module of the block.
package mmls_pkg;

    // Pixel type codes
    localparam logic [1:0] PIX_U8  = 2'd0;
    localparam logic [1:0] PIX_F16 = 2'd1;
    localparam logic [1:0] PIX_F32 = 2'd2;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH = 1'b0;
    localparam logic CFG_PIXEL_TYPE  = 1'b1;

    localparam int PIX_W   = 32;
    localparam int POS_W   = 16;
    localparam int WIDTH_W = 16;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd1920;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [POS_W-1:0] pos_t;

    // One frame result
    typedef struct packed {
        pos_t   max_col;
        pos_t   max_row;
        pos_t   min_col;
        pos_t   min_row;
        pixel_t max_value;
        pixel_t min_value;
    } result_t;

    // Keep only the bits that the pixel type uses
    function automatic pixel_t mask_pixel(input pixel_t raw, input logic [1:0] ptype);
        pixel_t v;
        begin
            case (ptype)
                PIX_U8:  v = {24'd0, raw[7:0]};
                PIX_F16: v = {16'd0, raw[15:0]};
                default: v = raw;
            endcase
            return v;
        end
    endfunction

    // Ordered integer key: floats become sign-magnitude flipped, -0 maps to +0
    function automatic pixel_t rank_key(input pixel_t raw, input logic [1:0] ptype);
        logic [15:0] h;
        pixel_t      s;
        pixel_t      k;
        begin
            h = raw[15:0];
            s = raw;
            case (ptype)
                PIX_U8:
                begin
                    k = {24'd0, raw[7:0]};
                end
                PIX_F16:
                begin
                    if (h == 16'h8000)
                        h = 16'h0000;
                    if (h[15])
                        k = {16'd0, ~h};
                    else
                        k = {16'd0, h | 16'h8000};
                end
                default:
                begin
                    if (s == 32'h8000_0000)
                        s = '0;
                    if (s[31])
                        k = ~s;
                    else
                        k = s | 32'h8000_0000;
                end
            endcase
            return k;
        end
    endfunction

endpackage

// ----- hw/rtl/min_max_location_search.sv -----
// min_max_location_search: frame minimum/maximum with first-occurrence row/column.
// The pixel carrying tlast is held in the input register; the result register loads when it moves on.
// Throughput: one pixel per cycle; the input register and result register decouple
// the two sides, so the input only stalls when a finished result is still held.
// Reset: asynchronous active low; image_width 1920, pixel_type u8, counters zero.
// Depends on mmls_pkg, mmls_pos, mmls_track.
module min_max_location_search
    import mmls_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [WIDTH_W-1:0] cfg_data,
    // Pixel stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // [31:0] pixel_bits
    input  logic               s_axis_tlast,   // frame_end
    // Result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [127:0]       m_axis_tdata    // min_value, max_value, min_row,
                                               // min_col, max_row, max_col
);

    logic [WIDTH_W-1:0] image_width_reg;
    logic [1:0]         pixel_type_reg;

    logic    in_valid_reg;
    pixel_t  in_pixel_reg;
    logic    in_last_reg;

    logic    out_valid_reg;
    result_t out_data_reg;

    logic    out_free;
    logic    step;
    logic    out_load;
    pos_t    row, col;
    result_t result;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= WIDTH_RESET;
            pixel_type_reg  <= PIX_U8;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: image_width_reg <= cfg_data;
                CFG_PIXEL_TYPE:  pixel_type_reg  <= cfg_data[1:0];
                default:         image_width_reg <= image_width_reg;
            endcase
        end
    end

    // Stage control: a held pixel moves on unless it closes a frame and the
    // result register is still occupied
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && (!in_last_reg || out_free);
    assign out_load      = step && in_last_reg;
    assign s_axis_tready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_pixel_reg <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
        end
    end

    mmls_pos #(
        .COORD_BITS (COORD_BITS)
    ) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .frame_end   (in_last_reg),
        .image_width (image_width_reg),
        .row         (row),
        .col         (col)
    );

    mmls_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .pixel      (in_pixel_reg),
        .frame_end  (in_last_reg),
        .pixel_type (pixel_type_reg),
        .row        (row),
        .col        (col),
        .result     (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- hw/rtl/mmls_pos.sv -----
// Raster position counters: column wraps at the configured width, row advances.
// Depends on mmls_pkg.
module mmls_pos
    import mmls_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,       // one pixel consumed
    input  logic               frame_end,  // pixel closes the frame
    input  logic [WIDTH_W-1:0] image_width,
    output pos_t               row,
    output pos_t               col
);

    localparam int CMP_W = (COORD_BITS + 1 > WIDTH_W) ? COORD_BITS + 1 : WIDTH_W;

    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS:0]   col_inc;
    logic                  wrap;

    // Next column and wrap decision
    always_comb
    begin
        col_inc = {1'b0, col_reg} + {{COORD_BITS{1'b0}}, 1'b1};
        wrap    = col_inc[COORD_BITS] ||
                  ((image_width != '0) && (CMP_W'(col_inc) >= CMP_W'(image_width)));
        row_next = row_reg;
        col_next = col_reg;
        if (step)
        begin
            if (frame_end)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (wrap)
            begin
                row_next = row_reg + {{(COORD_BITS-1){1'b0}}, 1'b1};
                col_next = '0;
            end
            else
            begin
                col_next = col_inc[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign row = POS_W'(row_reg);
    assign col = POS_W'(col_reg);

endmodule

// ----- hw/rtl/mmls_track.sv -----
// Running minimum / maximum tracker with first-occurrence position.
// Depends on mmls_pkg.
module mmls_track
    import mmls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,        // one pixel consumed
    input  pixel_t     pixel,       // raw pixel bits
    input  logic       frame_end,
    input  logic [1:0] pixel_type,
    input  pos_t       row,
    input  pos_t       col,
    output result_t    result       // extremes including this pixel
);

    pixel_t best_low_reg, best_high_reg;
    pos_t   low_row_reg, low_col_reg, high_row_reg, high_col_reg;
    logic   first_reg;

    pixel_t px;
    pixel_t key;
    logic   take_low, take_high;

    // Rank the new pixel against the kept extremes
    always_comb
    begin
        px        = mask_pixel(pixel, pixel_type);
        key       = rank_key(px, pixel_type);
        take_low  = first_reg || (key < rank_key(best_low_reg, pixel_type));
        take_high = first_reg || (key > rank_key(best_high_reg, pixel_type));

        result.min_value = take_low  ? px  : best_low_reg;
        result.min_row   = take_low  ? row : low_row_reg;
        result.min_col   = take_low  ? col : low_col_reg;
        result.max_value = take_high ? px  : best_high_reg;
        result.max_row   = take_high ? row : high_row_reg;
        result.max_col   = take_high ? col : high_col_reg;
    end

    // Kept extremes: payload without reset, start-of-frame flag with reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            best_low_reg  <= result.min_value;
            low_row_reg   <= result.min_row;
            low_col_reg   <= result.min_col;
            best_high_reg <= result.max_value;
            high_row_reg  <= result.max_row;
            high_col_reg  <= result.max_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_reg <= 1'b1;
        else if (step)
            first_reg <= frame_end;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for min_max_location_search: pixel frames go in, and the
// frame extremes with their first row and column are checked against a local tracker.
// Depends on mmls_pkg and the min_max_location_search RTL.
module testbench;
    import mmls_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles with no request accepted anywhere
    localparam int PIXEL_ITEMS = 850;    // random part
    localparam int SETTLE      = 4;      // cycles after the last result before a write

    typedef enum logic [1:0] {ST_PIXEL, ST_LAST, ST_WIDTH, ST_TYPE} plan_kind_t;

    // One stimulus row; the lo_*/hi_* fields are used only when known is set
    typedef struct packed {
        plan_kind_t  kind;
        logic [31:0] bits;
        logic        known;
        logic [31:0] lo_v;
        logic [31:0] hi_v;
        logic [15:0] lo_r;
        logic [15:0] lo_c;
        logic [15:0] hi_r;
        logic [15:0] hi_c;
    } plan_row_t;

    localparam plan_row_t PLAN [36] = '{
        // single pixel frame after reset; upper bits dropped in u8 mode
        '{ST_LAST,  32'hABCD_EF12, 1'b1, 32'h12, 32'h12, 16'd0, 16'd0, 16'd0, 16'd0},
        // u8 extremes; a later equal minimum is not taken
        '{ST_PIXEL, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_00FF, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_LAST,  32'h0000_0100, 1'b1, 32'h00, 32'hFF, 16'd0, 16'd0, 16'd0, 16'd1},
        // narrow rows
        '{ST_WIDTH, 32'd3,         1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_0080, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_0010, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_0090, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_0010, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_LAST,  32'h0000_0005, 1'b1, 32'h05, 32'h90, 16'd1, 16'd1, 16'd0, 16'd2},
        // half floats: signed zeros, infinities, NaNs
        '{ST_TYPE,  32'd1,         1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'hFFFF_8000, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_7C00, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_FC00, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_7E00, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_LAST,  32'h0000_FE00, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        // single floats with zero width
        '{ST_TYPE,  32'd2,         1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_WIDTH, 32'd0,         1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'hFF80_0000, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h7F80_0000, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_LAST,  32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        // unused type code ranks as single; widest row
        '{ST_TYPE,  32'd3,         1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_WIDTH, 32'd65535,     1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h3F80_0000, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_LAST,  32'hBF80_0000, 1'b1, 32'hBF80_0000, 32'h3F80_0000,
          16'd0, 16'd1, 16'd0, 16'd0},
        // type and width change in mid frame; width drops below the column
        '{ST_TYPE,  32'hFFFC,      1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_WIDTH, 32'd2,         1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_1234, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_TYPE,  32'd1,         1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_WIDTH, 32'd1,         1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_PIXEL, 32'h0000_8001, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ST_LAST,  32'h0000_0002, 1'b0, 32'h0, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = CFG_IMAGE_WIDTH;
    logic [WIDTH_W-1:0] cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata = '0;
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [127:0]       m_axis_tdata;

    // Local copy of the block's registers and frame state
    logic [15:0] width_reg = WIDTH_RESET;
    logic [1:0]  type_reg  = PIX_U8;
    logic [31:0] low_val   = '0;
    logic [31:0] high_val  = '0;
    logic [15:0] low_r     = '0;
    logic [15:0] low_c     = '0;
    logic [15:0] high_r    = '0;
    logic [15:0] high_c    = '0;
    logic [15:0] row_ctr   = '0;
    logic [15:0] col_ctr   = '0;
    bit          fresh     = 1'b1;

    result_t     frame_results_due [$];
    int          errors      = 0;
    int          idle_cycles = 0;
    int          hold_cycles = 0;
    bit          src_quiet   = 1'b0;
    bit          sink_quiet  = 1'b0;
    logic [31:0] last_sent   = '0;

    min_max_location_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [31:0] pixel_bits
        .s_axis_tlast  (s_axis_tlast),    // frame_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)     // min_value, max_value, min_row,
                                          // min_col, max_row, max_col
    );

    always #10 clk = ~clk;

    // Drop the bits that the current pixel type does not use
    function automatic logic [31:0] fit_to_type(input logic [31:0] raw);
        if (type_reg == PIX_U8)
            return {24'd0, raw[7:0]};
        if (type_reg == PIX_F16)
            return {16'd0, raw[15:0]};
        return raw;
    endfunction

    // Unsigned ordering key; floats: sign flips the magnitude, -0 ranks as +0
    function automatic logic [31:0] order_key(input logic [31:0] px);
        logic [15:0] h;
        logic [31:0] f;
        h = px[15:0];
        f = px;
        case (type_reg)
            PIX_U8:
                return {24'd0, px[7:0]};
            PIX_F16:
            begin
                if (h == 16'h8000)
                    h = '0;
                return {16'd0, h[15] ? ~h : {1'b1, h[14:0]}};
            end
            default:
            begin
                if (f == 32'h8000_0000)
                    f = '0;
                return f[31] ? ~f : {1'b1, f[30:0]};
            end
        endcase
    endfunction

    // Update the frame state with one pixel; a result comes out on the frame end
    task automatic track_pixel(input logic [31:0] raw, input logic last,
                               output logic has_out, output result_t out);
        logic [31:0] px;
        logic [31:0] key;
        logic [16:0] next_col;
        px  = fit_to_type(raw);
        key = order_key(px);
        if (fresh || key < order_key(low_val))
        begin
            low_val = px;
            low_r   = row_ctr;
            low_c   = col_ctr;
        end
        if (fresh || key > order_key(high_val))
        begin
            high_val = px;
            high_r   = row_ctr;
            high_c   = col_ctr;
        end
        fresh = 1'b0;

        // column wraps at the width, or at the counter's range when the width is 0
        next_col = {1'b0, col_ctr} + 17'd1;
        if (next_col[16] || (width_reg != '0 && next_col >= {1'b0, width_reg}))
        begin
            col_ctr = '0;
            row_ctr = row_ctr + 16'd1;
        end
        else
        begin
            col_ctr = next_col[15:0];
        end

        has_out = last;
        out     = '0;
        if (last)
        begin
            out.min_value = low_val;
            out.max_value = high_val;
            out.min_row   = low_r;
            out.min_col   = low_c;
            out.max_row   = high_r;
            out.max_col   = high_c;
            low_val  = '0;
            high_val = '0;
            low_r    = '0;
            low_c    = '0;
            high_r   = '0;
            high_c   = '0;
            row_ctr  = '0;
            col_ctr  = '0;
            fresh    = 1'b1;
        end
    endtask

    // Present one pixel request and wait for it to be taken, then idle a while
    task automatic send_pixel(input logic [31:0] bits, input logic last,
                              input logic known, input result_t typed);
        logic    has_out;
        result_t predicted;
        int      gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bits;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_pixel(bits, last, has_out, predicted);
        if (has_out)
            frame_results_due.push_back(known ? typed : predicted);
        last_sent = bits;
        gap = src_quiet ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let every expected frame result come out and the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_IMAGE_WIDTH)
            width_reg = data;
        else
            type_reg = data[1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly random bits, with repeats, zeros, all ones, signed zeros and infinities
    function automatic logic [31:0] pick_pixel();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            5: r = last_sent;
            6: r = 32'h0;
            7: r = 32'hFFFF_FFFF;
            8: r = (type_reg == PIX_F16) ? {r[31:16], 16'h8000} : 32'h8000_0000;
            9: r = (type_reg == PIX_F16) ? {r[31:16], r[0], 15'h7C00}
                                         : {r[0], 31'h7F80_0000};
            default: ;
        endcase
        return r;
    endfunction

    // Mostly short frames so that results come often
    function automatic int frame_length();
        case ($urandom_range(0, 9))
            0:       return 1;
            1, 2:    return $urandom_range(13, 40);
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    function automatic logic [15:0] pick_width();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd65535;
            3:       return 16'($urandom_range(2, 4));
            4:       return 16'($urandom_range(1, 65535));
            default: return 16'($urandom_range(2, 16));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: check each accepted result, then hold tready low for a while
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (frame_results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = frame_results_due.pop_front();
                    check_field("min_value", want.min_value, got.min_value);
                    check_field("max_value", want.max_value, got.max_value);
                    check_field("min_row", 32'(want.min_row), 32'(got.min_row));
                    check_field("min_col", 32'(want.min_col), 32'(got.min_col));
                    check_field("max_row", 32'(want.max_row), 32'(got.max_row));
                    check_field("max_col", 32'(want.max_col), 32'(got.max_col));
                end
                hold_cycles = sink_quiet ? 0 : $urandom_range(0, 12);
            end
            else if (hold_cycles != 0)
            begin
                hold_cycles--;
            end
            m_axis_tready <= (hold_cycles == 0);
        end
    end

    // Watchdog: give up when no request moves on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        result_t     typed;
        int          sent;
        int          left;
        int          n;
        logic        last;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (PLAN[i])
        begin
            case (PLAN[i].kind)
                ST_WIDTH:
                begin
                    settle();
                    write_register(CFG_IMAGE_WIDTH, PLAN[i].bits[15:0]);
                end
                ST_TYPE:
                begin
                    settle();
                    write_register(CFG_PIXEL_TYPE, PLAN[i].bits[15:0]);
                end
                default:
                begin
                    typed           = '0;
                    typed.min_value = PLAN[i].lo_v;
                    typed.max_value = PLAN[i].hi_v;
                    typed.min_row   = PLAN[i].lo_r;
                    typed.min_col   = PLAN[i].lo_c;
                    typed.max_row   = PLAN[i].hi_r;
                    typed.max_col   = PLAN[i].hi_c;
                    send_pixel(PLAN[i].bits, PLAN[i].kind == ST_LAST, PLAN[i].known, typed);
                end
            endcase
        end

        // Random phases; a frame may stay open across a register write
        sent = 0;
        left = frame_length();
        while (sent < PIXEL_ITEMS)
        begin
            settle();
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    write_register(CFG_IMAGE_WIDTH, pick_width());
                if ($urandom_range(0, 3) != 0)
                    write_register(CFG_PIXEL_TYPE, 16'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    write_register(CFG_PIXEL_TYPE, 16'($urandom));
                if ($urandom_range(0, 3) != 0)
                    write_register(CFG_IMAGE_WIDTH, pick_width());
            end
            n = $urandom_range(10, 60);
            repeat (n)
            begin
                left--;
                last = (left == 0);
                send_pixel(pick_pixel(), last, 1'b0, '0);
                sent++;
                if (last)
                    left = frame_length();
            end
        end

        // Drain and report
        s_axis_tvalid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
